// ===== design/lruk_pkg.sv =====
`timescale 1ns / 1ps

package lruk_pkg;

	localparam int PAGE_W     = 14;
	localparam int CNT_W      = 8;
	localparam int FUNC_W     = 2;
	localparam int SLOT_W     = 4;
	localparam int KIND_W     = 3;
	localparam int LEN_W      = 5;
	localparam int THR_W      = 8;
	localparam int QSIZE_W    = 5;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;
	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

	localparam logic [FUNC_W-1:0] FN_ACCESS   = 2'd0;
	localparam logic [FUNC_W-1:0] FN_RD_HIST  = 2'd1;
	localparam logic [FUNC_W-1:0] FN_RD_CACHE = 2'd2;

	localparam logic [KIND_W-1:0] KIND_CACHE_HIT = 3'd0;
	localparam logic [KIND_W-1:0] KIND_HIST_HIT  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_PROMOTED  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_NEW       = 3'd3;
	localparam logic [KIND_W-1:0] KIND_READOUT   = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_QSIZE     = 1'b1;

	localparam logic [THR_W-1:0]   THRESHOLD_RST = 8'd2;
	localparam logic [QSIZE_W-1:0] QSIZE_RST     = 5'd16;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_UPD
	} state_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [PAGE_W-1:0] page;
		logic [SLOT_W-1:0] slot;
	} in_item_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              evicted_valid;
		logic [PAGE_W-1:0] evicted_page;
		logic              evicted_from;
		logic              read_valid;
		logic [PAGE_W-1:0] read_page;
		logic [LEN_W-1:0]  history_length;
		logic [LEN_W-1:0]  cache_length;
	} out_item_t;

	typedef struct packed {
		logic cmp;
		logic valid;
		logic shift;
		logic load;
	} cell_ctl_t;

endpackage

// ===== design/lru_k_page_replacement_top.sv =====
`timescale 1ns / 1ps

// channel   ports                                  handshake
// item in   start, busy, item                      taken when start && !busy
// result    done, result                           one-cycle strobe, no stall
// config    cfg_valid, cfg_ready, cfg_index, cfg_data  written when valid && ready
//
// each item passes a compare state, which compares the page in every cell, then
// an update state, which shifts and loads the chain of cells and registers the result
// the result strobe comes in the cycle after the update; busy is high only
// in the compare state, so a new item can be taken while the last one is in update
// reset empties both queues and restores threshold 2 and queue size 16
// results cannot be held off; the config port is always ready

module lru_k_page_replacement_top import lruk_pkg::*; #(
	parameter int QUEUE_DEPTH = 16,
	parameter int PAGE_BITS   = 14
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  in_item_t              item,
	output logic                  done,
	output out_item_t             result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int SW  = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;
	localparam int HDW = CNT_W + SW;
	localparam int FW  = $clog2(QUEUE_DEPTH + 1);

	state_t              state_q, state_d;
	logic                cmp_en, upd;
	in_item_t            item_q;
	logic [THR_W-1:0]    thresh_q;
	logic [QSIZE_W-1:0]  qsize_q;
	logic [FW-1:0]       hfill_q, cfill_q, hfill_d, cfill_d;
	logic [FW-1:0]       sz;
	logic                done_q;
	out_item_t           result_q, result_d;

	logic [HDW-1:0]         h_data [QUEUE_DEPTH];
	logic [SW-1:0]          c_data [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] h_hit, c_hit;
	logic [QUEUE_DEPTH:0]   h_gap, c_gap;
	cell_ctl_t              h_ctl [QUEUE_DEPTH];
	cell_ctl_t              c_ctl [QUEUE_DEPTH];

	logic [SW-1:0]    key;
	logic             is_acc, cache_hit, hist_hit, promote, new_page;
	logic             h_full, c_full, h_evict, c_evict;
	logic [CNT_W-1:0] hit_cnt, cnt_inc;
	logic             h_load_en, c_load_en;
	logic [FW-1:0]    h_load_pos, c_load_pos;
	logic [HDW-1:0]   h_new;
	logic [SW-1:0]    rd_sel;
	logic             rd_valid;

	// control
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_CMP;
				end
			end
			ST_CMP: begin
				state_d = ST_UPD;
			end
			ST_UPD: begin
				state_d = start ? ST_CMP : ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy   = 1'b0;
		cmp_en = 1'b0;
		upd    = 1'b0;
		case (state_q)
			ST_CMP: begin
				busy   = 1'b1;
				cmp_en = 1'b1;
			end
			ST_UPD: begin
				upd = 1'b1;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			item_q <= item;
		end
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESHOLD_RST;
			qsize_q  <= QSIZE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_THRESHOLD: thresh_q <= cfg_data[THR_W-1:0];
				REG_QSIZE:     qsize_q  <= cfg_data[QSIZE_W-1:0];
				default:       thresh_q <= thresh_q;
			endcase
		end
	end

	// size in use
	always_comb begin
		if (qsize_q == '0) begin
			sz = FW'(1);
		end else if (7'(qsize_q) > 7'(QUEUE_DEPTH)) begin
			sz = FW'(QUEUE_DEPTH);
		end else begin
			sz = FW'(qsize_q);
		end
	end

	assign key = item_q.page[SW-1:0];

	// decision
	always_comb begin
		hit_cnt = '0;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if (h_hit[i]) begin
				hit_cnt = hit_cnt | h_data[i][HDW-1:SW];
			end
		end
	end

	assign is_acc    = item_q.func == FN_ACCESS;
	assign cache_hit = is_acc && (|c_hit);
	assign hist_hit  = is_acc && !cache_hit && (|h_hit);
	assign new_page  = is_acc && !cache_hit && !hist_hit;
	assign cnt_inc   = (hit_cnt == CNT_MAX) ? hit_cnt : hit_cnt + CNT_ONE;
	assign promote   = hist_hit && (cnt_inc >= thresh_q);
	assign h_full    = hfill_q >= sz;
	assign c_full    = cfill_q >= sz;
	assign h_evict   = new_page && h_full;
	assign c_evict   = promote && c_full;

	assign h_gap[0] = upd && h_evict;
	assign c_gap[0] = upd && c_evict;

	assign h_load_en  = upd && ((hist_hit && !promote) || new_page);
	assign h_load_pos = (hist_hit || h_full) ? hfill_q - FW'(1) : hfill_q;
	assign h_new      = {hist_hit ? cnt_inc : CNT_ONE, key};
	assign c_load_en  = upd && (cache_hit || promote);
	assign c_load_pos = (cache_hit || c_full) ? cfill_q - FW'(1) : cfill_q;

	// chains of cells
	genvar gi;
	generate
		for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
			logic [HDW-1:0] h_next;
			logic [SW-1:0]  c_next;

			if (gi < QUEUE_DEPTH - 1) begin : g_mid
				assign h_next = h_data[gi+1];
				assign c_next = c_data[gi+1];
			end else begin : g_end
				assign h_next = '0;
				assign c_next = '0;
			end

			always_comb begin
				h_ctl[gi].cmp   = cmp_en;
				h_ctl[gi].valid = hfill_q > FW'(gi);
				h_ctl[gi].shift = upd && is_acc && h_gap[gi+1] && (hfill_q > FW'(gi + 1));
				h_ctl[gi].load  = h_load_en && (h_load_pos == FW'(gi));
				c_ctl[gi].cmp   = cmp_en;
				c_ctl[gi].valid = cfill_q > FW'(gi);
				c_ctl[gi].shift = upd && is_acc && c_gap[gi+1] && (cfill_q > FW'(gi + 1));
				c_ctl[gi].load  = c_load_en && (c_load_pos == FW'(gi));
			end

			lruk_cell #(
				.DW(HDW),
				.KW(SW)
			) u_hcell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctl      (h_ctl[gi]),
				.key      (key),
				.next_data(h_next),
				.new_data (h_new),
				.gap_in   (h_gap[gi]),
				.gap_out  (h_gap[gi+1]),
				.hit      (h_hit[gi]),
				.data     (h_data[gi])
			);

			lruk_cell #(
				.DW(SW),
				.KW(SW)
			) u_ccell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctl      (c_ctl[gi]),
				.key      (key),
				.next_data(c_next),
				.new_data (key),
				.gap_in   (c_gap[gi]),
				.gap_out  (c_gap[gi+1]),
				.hit      (c_hit[gi]),
				.data     (c_data[gi])
			);
		end
	endgenerate

	// fills
	always_comb begin
		hfill_d = hfill_q;
		cfill_d = cfill_q;
		if (upd) begin
			if (promote) begin
				hfill_d = hfill_q - FW'(1);
			end else if (new_page && !h_full) begin
				hfill_d = hfill_q + FW'(1);
			end
			if (promote && !c_full) begin
				cfill_d = cfill_q + FW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hfill_q <= '0;
			cfill_q <= '0;
		end else begin
			hfill_q <= hfill_d;
			cfill_q <= cfill_d;
		end
	end

	// readout
	always_comb begin
		rd_sel = '0;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if (int'(item_q.slot) == i) begin
				rd_sel = (item_q.func == FN_RD_HIST) ? h_data[i][SW-1:0] : c_data[i];
			end
		end
	end

	always_comb begin
		case (item_q.func)
			FN_RD_HIST:  rd_valid = 7'(item_q.slot) < 7'(hfill_q);
			FN_RD_CACHE: rd_valid = 7'(item_q.slot) < 7'(cfill_q);
			default:     rd_valid = 1'b0;
		endcase
	end

	// result
	always_comb begin
		result_d = '0;
		if (!is_acc) begin
			result_d.kind = KIND_READOUT;
		end else if (cache_hit) begin
			result_d.kind = KIND_CACHE_HIT;
		end else if (hist_hit) begin
			result_d.kind = promote ? KIND_PROMOTED : KIND_HIST_HIT;
		end else begin
			result_d.kind = KIND_NEW;
		end
		result_d.evicted_valid = h_evict || c_evict;
		result_d.evicted_from  = c_evict;
		if (c_evict) begin
			result_d.evicted_page = PAGE_W'(c_data[0]);
		end else if (h_evict) begin
			result_d.evicted_page = PAGE_W'(h_data[0][SW-1:0]);
		end
		result_d.read_valid     = rd_valid;
		result_d.read_page      = rd_valid ? PAGE_W'(rd_sel) : '0;
		result_d.history_length = LEN_W'(hfill_d);
		result_d.cache_length   = LEN_W'(cfill_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= upd;
		end
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			result_q <= result_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;

`ifndef ASSERT_OFF
	a_start_to_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> state_q == ST_CMP)
		else $error("accepted item did not enter compare");

	a_done_after_upd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_UPD))
		else $error("result strobe without update");

	a_hit_unique: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_UPD |-> $onehot0(h_hit) && $onehot0(c_hit) && !((|h_hit) && (|c_hit)))
		else $error("page held in more than one slot");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hfill_q <= FW'(QUEUE_DEPTH) && cfill_q <= FW'(QUEUE_DEPTH))
		else $error("queue fill beyond depth");
`endif

endmodule

// ===== design/lruk_cell.sv =====
`timescale 1ns / 1ps

module lruk_cell import lruk_pkg::*; #(
	parameter int DW = 14,
	parameter int KW = 14
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cell_ctl_t     ctl,
	input  logic [KW-1:0] key,
	input  logic [DW-1:0] next_data,
	input  logic [DW-1:0] new_data,
	input  logic          gap_in,
	output logic          gap_out,
	output logic          hit,
	output logic [DW-1:0] data
);

	logic [DW-1:0] data_q;
	logic          hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctl.cmp) begin
			hit_q <= ctl.valid && (data_q[KW-1:0] == key);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			data_q <= new_data;
		end else if (ctl.shift) begin
			data_q <= next_data;
		end
	end

	// gap runs up the chain from the matching or evicted slot
	assign gap_out = gap_in | hit_q;
	assign hit     = hit_q;
	assign data    = data_q;

endmodule

// ===== tb/sv/lru_k_page_replacement_top_tb.sv =====
`timescale 1ns / 1ps

module lru_k_page_replacement_top_tb;
	import lruk_pkg::*;

	localparam int DEPTH = 16;
	localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	in_item_t              item = '0;
	logic                  done;
	out_item_t             result;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	lru_k_page_replacement_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// shadow of the replacement queues
	logic [PAGE_W-1:0] hist_pg[DEPTH];
	logic [CNT_W-1:0]  hist_cnt[DEPTH];
	logic [PAGE_W-1:0] cache_pg[DEPTH];
	int                hist_n = 0;
	int                cache_n = 0;
	logic [THR_W-1:0]   thr_reg = THRESHOLD_RST;
	logic [QSIZE_W-1:0] qsize_reg = QSIZE_RST;

	out_item_t expected_results[$];
	out_item_t oldest;
	int        errors = 0;
	bit        burst = 1'b0;

	function automatic int eff_size(input logic [QSIZE_W-1:0] qs);
		if (qs == 0)
			return 1;
		if (qs > DEPTH)
			return DEPTH;
		return qs;
	endfunction

	function automatic void hist_drop(input int p);
		for (int i = p; i < hist_n - 1; i++) begin
			hist_pg[i] = hist_pg[i + 1];
			hist_cnt[i] = hist_cnt[i + 1];
		end
	endfunction

	function automatic void cache_drop(input int p);
		for (int i = p; i < cache_n - 1; i++)
			cache_pg[i] = cache_pg[i + 1];
	endfunction

	function automatic out_item_t replace_page(input in_item_t it);
		out_item_t r;
		int cpos;
		int hpos;
		int sz;
		logic [CNT_W-1:0] cnt;
		r = '0;
		r.kind = KIND_READOUT;
		sz = eff_size(qsize_reg);
		cpos = -1;
		hpos = -1;
		case (it.func)
			FN_ACCESS: begin
				for (int i = cache_n - 1; i >= 0; i--)
					if (cache_pg[i] == it.page)
						cpos = i;
				for (int i = hist_n - 1; i >= 0; i--)
					if (hist_pg[i] == it.page)
						hpos = i;
				if (cpos >= 0) begin
					cache_drop(cpos);
					cache_pg[cache_n - 1] = it.page;
					r.kind = KIND_CACHE_HIT;
				end else if (hpos >= 0) begin
					cnt = hist_cnt[hpos];
					if (cnt != CNT_MAX)
						cnt++;
					hist_drop(hpos);
					if (cnt >= thr_reg) begin
						hist_n--;
						if (cache_n < sz) begin
							cache_pg[cache_n] = it.page;
							cache_n++;
						end else begin
							r.evicted_valid = 1'b1;
							r.evicted_page = cache_pg[0];
							r.evicted_from = 1'b1;
							cache_drop(0);
							cache_pg[cache_n - 1] = it.page;
						end
						r.kind = KIND_PROMOTED;
					end else begin
						hist_pg[hist_n - 1] = it.page;
						hist_cnt[hist_n - 1] = cnt;
						r.kind = KIND_HIST_HIT;
					end
				end else begin
					if (hist_n < sz) begin
						hist_n++;
					end else begin
						r.evicted_valid = 1'b1;
						r.evicted_page = hist_pg[0];
						r.evicted_from = 1'b0;
						hist_drop(0);
					end
					hist_pg[hist_n - 1] = it.page;
					hist_cnt[hist_n - 1] = CNT_ONE;
					r.kind = KIND_NEW;
				end
			end
			FN_RD_HIST: begin
				if (it.slot < hist_n) begin
					r.read_valid = 1'b1;
					r.read_page = hist_pg[it.slot];
				end
			end
			FN_RD_CACHE: begin
				if (it.slot < cache_n) begin
					r.read_valid = 1'b1;
					r.read_page = cache_pg[it.slot];
				end
			end
			default: ;
		endcase
		r.history_length = LEN_W'(hist_n);
		r.cache_length = LEN_W'(cache_n);
		return r;
	endfunction

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (expected_results.size() == 0) begin
					$error("result with no item outstanding");
					errors++;
				end else begin
					oldest = expected_results.pop_front();
					check_field("kind", oldest.kind, result.kind);
					check_field("evicted_valid", oldest.evicted_valid, result.evicted_valid);
					check_field("evicted_page", oldest.evicted_page, result.evicted_page);
					check_field("evicted_from", oldest.evicted_from, result.evicted_from);
					check_field("read_valid", oldest.read_valid, result.read_valid);
					check_field("read_page", oldest.read_page, result.read_page);
					check_field("history_length", oldest.history_length,
						result.history_length);
					check_field("cache_length", oldest.cache_length, result.cache_length);
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_THRESHOLD)
					thr_reg = cfg_data;
				else
					qsize_reg = cfg_data[QSIZE_W-1:0];
			end
			if (start && !busy)
				expected_results.push_back(replace_page(item));
		end
	end

	function automatic in_item_t mk(input logic [FUNC_W-1:0] f,
			input logic [PAGE_W-1:0] p, input logic [SLOT_W-1:0] s);
		in_item_t it;
		it.func = f;
		it.page = p;
		it.slot = s;
		return it;
	endfunction

	task automatic send_item(input in_item_t it);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 8);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item <= it;
		start <= 1'b1;
		do @(posedge clk); while (busy);
	endtask

	task automatic drain;
		start <= 1'b0;
		do @(posedge clk); while (expected_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_empty_reads;
		send_item(mk(FN_RD_HIST, '0, '0));
		send_item(mk(FN_RD_HIST, '1, '1));
		send_item(mk(FN_RD_CACHE, '0, '0));
		send_item(mk(FN_RD_CACHE, '1, '1));
		send_item(mk(FN_UNUSED, '1, '1));
		drain();
	endtask

	task automatic test_access_flow;
		send_item(mk(FN_ACCESS, '0, '0));
		send_item(mk(FN_ACCESS, '1, '1));
		send_item(mk(FN_ACCESS, 14'd100, '0));
		send_item(mk(FN_ACCESS, '1, '0));
		send_item(mk(FN_ACCESS, '1, '0));
		send_item(mk(FN_RD_HIST, '0, 4'd0));
		send_item(mk(FN_RD_HIST, '1, 4'd1));
		send_item(mk(FN_RD_CACHE, '0, 4'd0));
		drain();
	endtask

	// queue size dropped below the fill, size zero, size above the depth and low thresholds
	task automatic test_small_queues;
		write_reg(REG_QSIZE, 8'd2);
		send_item(mk(FN_ACCESS, 14'd200, '0));
		send_item(mk(FN_ACCESS, 14'd300, '0));
		drain();
		write_reg(REG_QSIZE, 8'd0);
		send_item(mk(FN_ACCESS, 14'd200, '0));
		drain();
		write_reg(REG_THRESHOLD, 8'd3);
		send_item(mk(FN_ACCESS, 14'd400, '0));
		send_item(mk(FN_ACCESS, 14'd400, '0));
		drain();
		write_reg(REG_THRESHOLD, 8'd1);
		send_item(mk(FN_ACCESS, 14'd400, '0));
		drain();
		write_reg(REG_QSIZE, 8'd31);
		write_reg(REG_THRESHOLD, 8'd0);
		send_item(mk(FN_ACCESS, 14'd7, '0));
		send_item(mk(FN_ACCESS, 14'd7, '0));
		drain();
	endtask

	task automatic test_random_phase(input logic [THR_W-1:0] thr,
			input logic [QSIZE_W-1:0] qs, input int n);
		logic [PAGE_W-1:0] pool[40];
		logic [2:0] hi;
		int pool_n;
		int sz;
		int r;
		in_item_t it;
		hi = 3'($urandom_range(0, 7));
		write_reg(REG_THRESHOLD, thr);
		write_reg(REG_QSIZE, {hi, qs});
		sz = eff_size(qs);
		pool_n = 2 * sz + $urandom_range(1, 4);
		if (pool_n > 40)
			pool_n = 40;
		for (int i = 0; i < pool_n; i++)
			pool[i] = PAGE_W'($urandom_range(0, (1 << PAGE_W) - 1));
		for (int k = 0; k < n; k++) begin
			if (k % 50 == 0)
				burst = ($urandom_range(0, 2) == 0);
			r = $urandom_range(0, 99);
			it.page = PAGE_W'($urandom_range(0, (1 << PAGE_W) - 1));
			it.slot = $urandom_range(0, 1) ? SLOT_W'($urandom_range(0, 15)) :
				SLOT_W'($urandom_range(0, sz - 1));
			if (r < 72) begin
				it.func = FN_ACCESS;
				if ($urandom_range(0, 99) < 88)
					it.page = pool[$urandom_range(0, pool_n - 1)];
			end else if (r < 84) begin
				it.func = FN_RD_HIST;
			end else if (r < 96) begin
				it.func = FN_RD_CACHE;
			end else begin
				it.func = FN_UNUSED;
			end
			send_item(it);
		end
		burst = 1'b0;
		drain();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_empty_reads();
		test_access_flow();
		test_small_queues();
		test_random_phase(8'd2, 5'd16, 190);
		test_random_phase(8'd1, 5'd16, 190);
		test_random_phase(8'd0, 5'd4, 190);
		test_random_phase(8'd255, 5'd2, 190);
		test_random_phase(8'd3, 5'd0, 190);
		test_random_phase(8'd4, 5'd31, 190);
		test_random_phase(THR_W'($urandom_range(1, 6)), QSIZE_W'($urandom_range(1, 16)), 180);
		test_random_phase(THR_W'($urandom_range(0, 255)), QSIZE_W'($urandom_range(0, 31)),
			180);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#1000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
